[hdl/crsh_pkg.sv]
// Shared types, constants and helpers for the segment cast block.
package crsh_pkg;

  localparam int COORD_BITS   = 32;
  localparam int BODY_ID_BITS = 8;
  localparam int T_FRAC       = 16;

  localparam int D_W      = COORD_BITS + 1;
  // room for disc * 2^(2T) and m*m without wrap
  localparam int WIDE_W   = 4 * (COORD_BITS + 2) + 2 * T_FRAC + 8;
  localparam int LEN_C    = D_W;
  localparam int LEN_W    = 2 * COORD_BITS + 5;
  localparam int LEN_M    = LEN_W + T_FRAC + 2;
  localparam int LEN_BITS = $clog2(LEN_M + 1);
  localparam int T_W      = T_FRAC + 1;
  localparam int BIDX_W   = $clog2(T_FRAC + 1);

  localparam logic [T_W-1:0] T_FULL = {1'b1, {T_FRAC{1'b0}}};

  typedef logic signed [WIDE_W-1:0]     wide_t;
  typedef logic signed [D_W-1:0]        diff_t;
  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef enum logic {OP_CIRCLE = 1'b0, OP_EDGE = 1'b1} op_t;

  typedef enum logic [1:0] {
    CFG_START_X = 2'd0,
    CFG_START_Y = 2'd1,
    CFG_END_X   = 2'd2,
    CFG_END_Y   = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t         opcode;
    logic [7:0]  body_id;
    coord_t      first_x;
    coord_t      first_y;
    coord_t      second_x;
    coord_t      second_y;
    logic        end_of_shape;
    logic        end_of_query;
  } shape_t;

  typedef struct packed {
    logic           hit;
    logic [7:0]     hit_body;
    logic [T_W-1:0] hit_t;
  } result_t;

  typedef struct packed {
    logic           hit;
    logic [T_W-1:0] t;
    logic           toggle;
  } seq_res_t;

  typedef struct packed {
    logic                start;
    logic [LEN_BITS-1:0] len;
  } mul_req_t;

  typedef enum logic [4:0] {
    S_IDLE, C_DXX, C_DYY, C_FXX, C_FYY, C_RR, C_CHK, C_FXD, C_FYD, C_HH, C_AC,
    C_DISC, C_EE, C_LOOP, C_MM, E_LHS, E_RHS, E_D1, E_D2, E_T1, E_T2, E_U1, E_U2,
    E_CHK, E_DIV, S_DONE
  } seq_state_t;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_POST} top_state_t;

  function automatic wide_t wext(input diff_t v);
    return {{(WIDE_W - D_W){v[D_W-1]}}, v};
  endfunction

  function automatic diff_t dsub(input coord_t a, input coord_t b);
    return {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
  endfunction

endpackage

[hdl/crsh_mul.sv]
// Bit-serial signed multiplier, one multiplier bit per cycle, LSB first.
module crsh_mul import crsh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  input  wide_t    a,
  input  wide_t    b,
  output wide_t    p,
  output logic     done
);

  wide_t               acc;
  wide_t               a_sh;
  wide_t               b_sh;
  wide_t               term;
  wide_t               sum;
  logic [LEN_BITS-1:0] cnt;
  logic                run;
  logic                last;

  always_comb begin
    term = b_sh[0] ? a_sh : '0;
    last = (cnt == '0);
    // top bit of the len-bit multiplier carries negative weight
    sum  = last ? acc - term : acc + term;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        run <= 1'b1;
        cnt <= req.len - LEN_BITS'(1);
      end else if (run) begin
        if (last) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - LEN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      acc  <= '0;
      a_sh <= a;
      b_sh <= b;
    end else if (run) begin
      acc  <= sum;
      a_sh <= a_sh <<< 1;
      b_sh <= b_sh >>> 1;
    end
  end

  assign p = acc;

endmodule

[hdl/crsh_seq.sv]
// Per-item sequencer: circle and edge cast on the shared serial multiplier.
module crsh_seq import crsh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  shape_t   item,
  input  coord_t   sx,
  input  coord_t   sy,
  input  coord_t   ex,
  input  coord_t   ey,
  output logic     done,
  output seq_res_t res
);

  seq_state_t state, state_next;
  logic       issued;

  mul_req_t mul_req;
  wide_t    mul_a, mul_b, mul_p;
  logic     mul_done;
  logic     is_mul;

  wide_t ra, rf, rg, rh, rx, ry, rm, ka, ash;
  logic [T_W-1:0]    rk, rt;
  logic [BIDX_W-1:0] bidx;
  logic              rhit, rtog;

  diff_t d_dx, d_dy, d_fx, d_fy, d_rad, e_x, e_y, q_x, q_y;
  wide_t hm_w, m_w, den_abs, tn_s, un_s, num2, num_next;
  logic [T_W-1:0] cand, k_mm;
  logic cand_over, edge_ok, ge, tog, mm_ok, ee_fail, circ_exit, disc_exit, loop_rej;
  logic b_last;

  crsh_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .req  (mul_req),
    .a    (mul_a),
    .b    (mul_b),
    .p    (mul_p),
    .done (mul_done)
  );

  always_comb begin
    d_dx  = dsub(ex, sx);
    d_dy  = dsub(ey, sy);
    d_fx  = dsub(sx, item.first_x);
    d_fy  = dsub(sy, item.first_y);
    d_rad = {item.second_x[COORD_BITS-1], item.second_x};
    e_x   = dsub(item.second_x, item.first_x);
    e_y   = dsub(item.second_y, item.first_y);
    q_x   = dsub(item.first_x, sx);
    q_y   = dsub(item.first_y, sy);

    hm_w      = -rh;
    cand      = rk | (T_W'(1) << bidx);
    cand_over = cand > T_FULL;
    m_w       = rx - (ka + ash);
    loop_rej  = cand_over || m_w[WIDE_W-1];
    mm_ok     = !(mul_p < ry);
    k_mm      = mm_ok ? cand : rk;
    ee_fail   = rg < mul_p;
    b_last    = (bidx == '0);
    circ_exit = (ra == '0) || !(rg < rf);
    disc_exit = rg[WIDE_W-1] || !rh[WIDE_W-1];

    den_abs = ra[WIDE_W-1] ? -ra : ra;
    tn_s    = ra[WIDE_W-1] ? -rh : rh;
    un_s    = ra[WIDE_W-1] ? -rx : rx;
    edge_ok = !tn_s[WIDE_W-1] && !un_s[WIDE_W-1] && !(den_abs < tn_s) && !(den_abs < un_s);

    num2     = (bidx == BIDX_W'(T_FRAC)) ? rf : rf <<< 1;
    ge       = !(num2 < rg);
    num_next = ge ? num2 - rg : num2;

    // crossing-parity: the edge straddles the start row and passes to its side
    tog = ((sy < item.first_y) != (sy < item.second_y)) &&
          (e_y[D_W-1] ? (rg < rf) : (rf < rg));
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (start) state_next = (item.opcode == OP_EDGE) ? E_LHS : C_DXX;
      C_DXX:  if (mul_done) state_next = C_DYY;
      C_DYY:  if (mul_done) state_next = C_FXX;
      C_FXX:  if (mul_done) state_next = C_FYY;
      C_FYY:  if (mul_done) state_next = C_RR;
      C_RR:   if (mul_done) state_next = C_CHK;
      C_CHK:  state_next = circ_exit ? S_DONE : C_FXD;
      C_FXD:  if (mul_done) state_next = C_FYD;
      C_FYD:  if (mul_done) state_next = C_HH;
      C_HH:   if (mul_done) state_next = C_AC;
      C_AC:   if (mul_done) state_next = C_DISC;
      C_DISC: state_next = disc_exit ? S_DONE : ((ra < hm_w) ? C_EE : C_LOOP);
      C_EE:   if (mul_done) state_next = ee_fail ? S_DONE : C_LOOP;
      C_LOOP: begin
        if (loop_rej) state_next = b_last ? S_DONE : C_LOOP;
        else          state_next = C_MM;
      end
      C_MM:   if (mul_done) state_next = b_last ? S_DONE : C_LOOP;
      E_LHS:  if (mul_done) state_next = E_RHS;
      E_RHS:  if (mul_done) state_next = E_D1;
      E_D1:   if (mul_done) state_next = E_D2;
      E_D2:   if (mul_done) state_next = E_T1;
      E_T1:   if (mul_done) state_next = E_T2;
      E_T2:   if (mul_done) state_next = E_U1;
      E_U1:   if (mul_done) state_next = E_U2;
      E_U2:   if (mul_done) state_next = E_CHK;
      E_CHK:  state_next = ((ra == '0) || !edge_ok) ? S_DONE : E_DIV;
      E_DIV:  state_next = b_last ? S_DONE : E_DIV;
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // multiplier operands and launch
  always_comb begin
    is_mul      = 1'b1;
    mul_a       = '0;
    mul_b       = '0;
    mul_req.len = LEN_BITS'(LEN_C);
    unique case (state)
      C_DXX: begin mul_a = wext(d_dx); mul_b = wext(d_dx); end
      C_DYY: begin mul_a = wext(d_dy); mul_b = wext(d_dy); end
      C_FXX: begin mul_a = wext(d_fx); mul_b = wext(d_fx); end
      C_FYY: begin mul_a = wext(d_fy); mul_b = wext(d_fy); end
      C_RR:  begin mul_a = wext(d_rad); mul_b = wext(d_rad); end
      C_FXD: begin mul_a = wext(d_fx); mul_b = wext(d_dx); end
      C_FYD: begin mul_a = wext(d_fy); mul_b = wext(d_dy); end
      C_HH:  begin mul_a = rh; mul_b = rh; mul_req.len = LEN_BITS'(LEN_W); end
      C_AC:  begin mul_a = ra; mul_b = rf; mul_req.len = LEN_BITS'(LEN_W); end
      C_EE:  begin mul_a = rf; mul_b = rf; mul_req.len = LEN_BITS'(LEN_W); end
      C_MM:  begin mul_a = rm; mul_b = rm; mul_req.len = LEN_BITS'(LEN_M); end
      E_LHS: begin mul_a = wext(d_fx); mul_b = wext(e_y); end
      E_RHS: begin mul_a = wext(e_x); mul_b = wext(d_fy); end
      E_D1:  begin mul_a = wext(d_dx); mul_b = wext(e_y); end
      E_D2:  begin mul_a = wext(d_dy); mul_b = wext(e_x); end
      E_T1:  begin mul_a = wext(q_x); mul_b = wext(e_y); end
      E_T2:  begin mul_a = wext(q_y); mul_b = wext(e_x); end
      E_U1:  begin mul_a = wext(q_x); mul_b = wext(d_dy); end
      E_U2:  begin mul_a = wext(q_y); mul_b = wext(d_dx); end
      default: is_mul = 1'b0;
    endcase
    mul_req.start = is_mul && !issued;
    done          = (state == S_DONE);
    res.hit       = rhit;
    res.t         = rt;
    res.toggle    = rtog;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
    end else begin
      state <= state_next;
      if (mul_req.start)  issued <= 1'b1;
      else if (mul_done)  issued <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: if (start) begin
        rhit <= 1'b0;
        rt   <= '0;
        rtog <= 1'b0;
      end
      C_DXX: if (mul_done) ra <= mul_p;
      C_DYY: if (mul_done) ra <= ra + mul_p;
      C_FXX: if (mul_done) rf <= mul_p;
      C_FYY: if (mul_done) rf <= rf + mul_p;
      C_RR:  if (mul_done) rg <= mul_p;
      C_CHK: begin
        if ((ra != '0) && !(rg < rf)) rhit <= 1'b1;   // start inside: t = 0
        rf <= rf - rg;
      end
      C_FXD: if (mul_done) rh <= mul_p;
      C_FYD: if (mul_done) rh <= rh + mul_p;
      C_HH:  if (mul_done) rg <= mul_p;
      C_AC:  if (mul_done) rg <= rg - mul_p;
      C_DISC: begin
        rx   <= hm_w <<< T_FRAC;
        ry   <= rg <<< (2 * T_FRAC);
        ash  <= ra <<< T_FRAC;
        ka   <= '0;
        rk   <= '0;
        bidx <= BIDX_W'(T_FRAC);
        rf   <= hm_w - ra;
      end
      C_LOOP: begin
        if (loop_rej) begin
          ash <= ash >>> 1;
          if (b_last) begin
            rhit <= 1'b1;
            rt   <= rk;
          end else begin
            bidx <= bidx - BIDX_W'(1);
          end
        end else begin
          rm <= m_w;
        end
      end
      C_MM: if (mul_done) begin
        rk  <= k_mm;
        if (mm_ok) ka <= ka + ash;
        ash <= ash >>> 1;
        if (b_last) begin
          rhit <= 1'b1;
          rt   <= k_mm;
        end else begin
          bidx <= bidx - BIDX_W'(1);
        end
      end
      E_LHS: if (mul_done) rf <= mul_p;
      E_RHS: if (mul_done) rg <= mul_p;
      E_D1:  if (mul_done) begin
        ra   <= mul_p;
        rtog <= tog;
      end
      E_D2:  if (mul_done) ra <= ra - mul_p;
      E_T1:  if (mul_done) rh <= mul_p;
      E_T2:  if (mul_done) rh <= rh - mul_p;
      E_U1:  if (mul_done) rx <= mul_p;
      E_U2:  if (mul_done) rx <= rx - mul_p;
      E_CHK: begin
        rg   <= den_abs;
        rf   <= tn_s;
        bidx <= BIDX_W'(T_FRAC);
        rt   <= '0;
      end
      E_DIV: begin
        rf <= num_next;
        rt <= {rt[T_W-2:0], ge};
        if (b_last) rhit <= 1'b1;
        else        bidx <= bidx - BIDX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

[hdl/closest_ray_shape_hit.sv]
// Top level: handshakes, configuration, per-shape and per-query accumulators.
//
// Casts the configured segment against a stream of circles and polygon edges
// and reports the nearest body hit once per query, on the item flagged
// end_of_query. All products run on one bit-serial signed multiplier, one bit
// per cycle, so an item takes as long as its chain of multiplies: a polygon
// edge runs eight 33-bit products plus a 17-step divide, a circle up to ten
// products, then a 17-step root search that squares an 87-bit value for each
// candidate it does not reject. shape_stall is high from acceptance until the
// item is folded into the accumulators. A finished result sits in an output
// register; the next item is accepted meanwhile, and only a second end of
// query waits until the first result transaction completes.
module closest_ray_shape_hit import crsh_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     shape_valid,
  output logic     shape_stall,
  input  shape_t   shape,
  output logic     result_valid,
  input  logic     result_stall,
  output result_t  result,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  coord_t   cfg_data
);

  top_state_t state, state_next;
  shape_t     item;
  coord_t     sx, sy, ex, ey;

  logic                    parity, shas, nvalid;
  logic [T_W-1:0]          sbest, nbest;
  logic [BODY_ID_BITS-1:0] nbody;

  logic                    parity_next, shas_next, nvalid_next;
  logic [T_W-1:0]          sbest_next, nbest_next;
  logic [BODY_ID_BITS-1:0] nbody_next;

  logic                    c_hit;
  logic [T_W-1:0]          c_t;
  logic [BODY_ID_BITS-1:0] body;
  result_t                 res_next;

  logic     accept, post_go;
  logic     seq_go;
  logic     seq_done;
  seq_res_t seq_res;

  // the sequencer starts once the accepted item sits in its register
  crsh_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (seq_go),
    .item  (item),
    .sx    (sx),
    .sy    (sy),
    .ex    (ex),
    .ey    (ey),
    .done  (seq_done),
    .res   (seq_res)
  );

  assign cfg_ready = 1'b1;
  assign accept    = shape_valid && !shape_stall;
  assign post_go   = (state == T_POST) &&
                     !(item.end_of_query && result_valid && result_stall);

  always_comb begin
    state_next = state;
    unique case (state)
      T_IDLE: if (accept)   state_next = T_RUN;
      T_RUN:  if (seq_done) state_next = T_POST;
      T_POST: if (post_go)  state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    shape_stall = (state != T_IDLE);
  end

  // fold the finished item into the accumulators
  always_comb begin
    body        = item.body_id[BODY_ID_BITS-1:0];
    parity_next = parity;
    shas_next   = shas;
    sbest_next  = sbest;
    nvalid_next = nvalid;
    nbest_next  = nbest;
    nbody_next  = nbody;
    c_hit       = 1'b0;
    c_t         = '0;

    if (item.opcode == OP_CIRCLE) begin
      c_hit = seq_res.hit;
      c_t   = seq_res.t;
    end else begin
      parity_next = parity ^ seq_res.toggle;
      if (seq_res.hit) begin
        if (!shas || (seq_res.t < sbest)) sbest_next = seq_res.t;
        shas_next = 1'b1;
      end
      if (item.end_of_shape) begin
        c_hit = parity_next || shas_next;
        c_t   = parity_next ? '0 : sbest_next;
        parity_next = 1'b0;
        shas_next   = 1'b0;
        sbest_next  = '0;
      end
    end

    // earlier body keeps a tie
    if (c_hit && (!nvalid || (c_t < nbest))) begin
      nvalid_next = 1'b1;
      nbest_next  = c_t;
      nbody_next  = body;
    end

    res_next.hit      = nvalid_next;
    res_next.hit_body = nvalid_next ? 8'(nbody_next) : 8'd0;
    res_next.hit_t    = nvalid_next ? nbest_next : '0;

    if (item.end_of_query) begin
      parity_next = 1'b0;
      shas_next   = 1'b0;
      sbest_next  = '0;
      nvalid_next = 1'b0;
      nbest_next  = '0;
      nbody_next  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= T_IDLE;
      seq_go <= 1'b0;
      parity <= 1'b0;
      shas   <= 1'b0;
      sbest  <= '0;
      nvalid <= 1'b0;
      nbest  <= '0;
      nbody  <= '0;
      result_valid <= 1'b0;
    end else begin
      state  <= state_next;
      seq_go <= accept;
      if (post_go) begin
        parity <= parity_next;
        shas   <= shas_next;
        sbest  <= sbest_next;
        nvalid <= nvalid_next;
        nbest  <= nbest_next;
        nbody  <= nbody_next;
      end
      if (post_go && item.end_of_query) result_valid <= 1'b1;
      else if (result_valid && !result_stall) result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) item <= shape;
    if (post_go && item.end_of_query) result <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sx <= '0;
      sy <= '0;
      ex <= '0;
      ey <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_START_X: sx <= cfg_data;
        CFG_START_Y: sy <= cfg_data;
        CFG_END_X:   ex <= cfg_data;
        CFG_END_Y:   ey <= cfg_data;
        default: ;
      endcase
    end
  end

  a_no_hit_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.hit |-> (result.hit_body == 8'd0) && (result.hit_t == '0))
    else $error("miss result carries nonzero body or t");

  a_t_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.hit_t <= T_FULL))
    else $error("hit_t above 1.0");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    seq_done |-> (state == T_RUN))
    else $error("sequencer finished outside run state");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> shape_stall && !seq_done)
    else $error("accepted item did not hold off the input");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for closest_ray_shape_hit: random and directed shape streams.
module testbench;
  import crsh_pkg::*;

  localparam int ONE = 65536;
  localparam int IDLE_LIMIT = 50000;
  localparam int DRAIN_CYCLES = 2500;

  typedef logic signed [319:0] big_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic shape_valid = 1'b0;
  logic shape_stall;
  shape_t shape = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  result_t result;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  cfg_idx_t cfg_index = CFG_START_X;
  coord_t cfg_data = '0;

  closest_ray_shape_hit dut (
    .clk(clk), .rst(rst),
    .shape_valid(shape_valid), .shape_stall(shape_stall), .shape(shape),
    .result_valid(result_valid), .result_stall(result_stall), .result(result),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  shape_t pending_shapes[$];
  result_t expected_hits[$];
  logic calm = 1'b0;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int n_items = 0;
  int n_results = 0;
  int n_hits = 0;
  int n_queued = 0;

  // predictor copy of the segment and accumulators
  coord_t seg_sx = '0, seg_sy = '0, seg_ex = '0, seg_ey = '0;
  logic poly_inside = 1'b0;
  logic poly_has_hit = 1'b0;
  logic [16:0] poly_best_t = '0;
  logic near_valid = 1'b0;
  logic [16:0] near_t = '0;
  logic [7:0] near_body = '0;

  function automatic big_t ext(input coord_t v);
    return big_t'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // circle cast: returns hit flag, t through t_out
  function automatic logic circle_cast(input shape_t s, output logic [16:0] t_out);
    big_t sx, sy, dx, dy, fx, fy, rad, a, ff, rr, h, c, disc, hm, e, x, y, m, full, k, cand;
    sx = ext(seg_sx); sy = ext(seg_sy);
    dx = ext(seg_ex) - sx; dy = ext(seg_ey) - sy;
    fx = sx - ext(s.first_x); fy = sy - ext(s.first_y);
    rad = ext(s.second_x);
    a = dx * dx + dy * dy;
    ff = fx * fx + fy * fy;
    rr = rad * rad;
    t_out = '0;
    if (a == 0) return 1'b0;
    if (rr >= ff) return 1'b1;
    h = fx * dx + fy * dy;
    c = ff - rr;
    disc = h * h - a * c;
    if (disc < 0 || h >= 0) return 1'b0;
    hm = -h;
    if (a < hm) begin
      e = hm - a;
      if (disc < e * e) return 1'b0;
    end
    full = big_t'(ONE);
    x = hm * full;
    y = disc * full * full;
    k = 0;
    for (int b = 16; b >= 0; b--) begin
      cand = k | (big_t'(1) <<< b);
      if (cand <= full) begin
        m = x - cand * a;
        if (m >= 0 && m * m >= y) k = cand;
      end
    end
    t_out = k[16:0];
    return 1'b1;
  endfunction

  task automatic edge_fold(input shape_t s);
    big_t sx, sy, rx, ry, x1, y1, x2, y2, ex, ey, lhs, rhs, den, qx, qy, tn, un, q;
    logic tog;
    sx = ext(seg_sx); sy = ext(seg_sy);
    rx = ext(seg_ex) - sx; ry = ext(seg_ey) - sy;
    x1 = ext(s.first_x); y1 = ext(s.first_y);
    x2 = ext(s.second_x); y2 = ext(s.second_y);
    ex = x2 - x1; ey = y2 - y1;
    if ((sy < y1) != (sy < y2)) begin
      lhs = (sx - x1) * ey;
      rhs = ex * (sy - y1);
      tog = (ey < 0) ? (rhs < lhs) : (lhs < rhs);
      if (tog) poly_inside = ~poly_inside;
    end
    den = rx * ey - ry * ex;
    if (den == 0) return;
    qx = x1 - sx; qy = y1 - sy;
    tn = qx * ey - qy * ex;
    un = qx * ry - qy * rx;
    if (den < 0) begin
      den = -den; tn = -tn; un = -un;
    end
    if (tn >= 0 && un >= 0 && tn <= den && un <= den) begin
      q = (tn <<< 16) / den;
      if (!poly_has_hit || q[16:0] < poly_best_t) poly_best_t = q[16:0];
      poly_has_hit = 1'b1;
    end
  endtask

  task automatic credit_body(input logic [7:0] body, input logic hit, input logic [16:0] t);
    if (hit && (!near_valid || t < near_t)) begin
      near_valid = 1'b1;
      near_t = t;
      near_body = body;
    end
  endtask

  task automatic predict_shape(input shape_t s);
    logic h;
    logic [16:0] t;
    result_t r;
    if (s.opcode == OP_CIRCLE) begin
      h = circle_cast(s, t);
      credit_body(s.body_id, h, t);
    end else begin
      edge_fold(s);
      if (s.end_of_shape) begin
        if (poly_inside) credit_body(s.body_id, 1'b1, '0);
        else credit_body(s.body_id, poly_has_hit, poly_best_t);
        poly_inside = 1'b0; poly_has_hit = 1'b0; poly_best_t = '0;
      end
    end
    if (s.end_of_query) begin
      r.hit = near_valid;
      r.hit_body = near_valid ? near_body : 8'd0;
      r.hit_t = near_valid ? near_t : 17'd0;
      expected_hits.push_back(r);
      poly_inside = 1'b0; poly_has_hit = 1'b0; poly_best_t = '0;
      near_valid = 1'b0; near_t = '0; near_body = '0;
    end
  endtask

  // shape driver
  always @(posedge clk) begin
    if (rst) begin
      shape_valid <= 1'b0;
      gap_left <= 0;
    end else if (!shape_valid || !shape_stall) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        shape_valid <= 1'b0;
      end else if (pending_shapes.size() != 0) begin
        shape <= pending_shapes.pop_front();
        shape_valid <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        shape_valid <= 1'b0;
      end
    end
  end

  // result receiver stalls
  always @(posedge clk) begin
    if (rst) begin
      result_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      result_stall <= !calm && ($urandom_range(0, 3) == 0);
      stall_left <= pick_gap();
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // acceptance, prediction and checking
  always @(posedge clk) begin
    result_t exp_r;
    if (!rst) begin
      if (shape_valid && !shape_stall) begin
        n_items++;
        predict_shape(shape);
      end
      if (result_valid && !result_stall) begin
        n_results++;
        if (expected_hits.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result transaction: hit=%0d body=%0d t=%0d",
                     result.hit, result.hit_body, result.hit_t);
        end else begin
          exp_r = expected_hits.pop_front();
          if (exp_r.hit) n_hits++;
          if (exp_r.hit !== result.hit || exp_r.hit_body !== result.hit_body ||
              exp_r.hit_t !== result.hit_t) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected hit=%0d body=%0d t=%0d, got hit=%0d body=%0d t=%0d",
                       exp_r.hit, exp_r.hit_body, exp_r.hit_t,
                       result.hit, result.hit_body, result.hit_t);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (shape_valid && !shape_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic shape_t mk(input op_t op, input logic [7:0] body, input int fx, input int fy,
                                input int sx, input int sy, input logic eos, input logic eoq);
    shape_t s;
    s.opcode = op; s.body_id = body;
    s.first_x = fx; s.first_y = fy; s.second_x = sx; s.second_y = sy;
    s.end_of_shape = eos; s.end_of_query = eoq;
    return s;
  endfunction

  function automatic int rnd_coord(input int span);
    return ($signed($urandom_range(0, 2 * span)) - span) * ONE + $signed($urandom_range(0, ONE - 1));
  endfunction

  task automatic push(input shape_t s);
    pending_shapes.push_back(s);
    n_queued++;
  endtask

  task automatic write_reg(input cfg_idx_t idx, input int val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_START_X: seg_sx = val;
      CFG_START_Y: seg_sy = val;
      CFG_END_X:   seg_ex = val;
      default:     seg_ey = val;
    endcase
  endtask

  task automatic set_segment(input int x0, input int y0, input int x1, input int y1);
    write_reg(CFG_START_X, x0);
    write_reg(CFG_START_Y, y0);
    write_reg(CFG_END_X, x1);
    write_reg(CFG_END_Y, y1);
  endtask

  // blocks until everything sent is answered, then lets the block settle
  task automatic wait_quiet();
    while (pending_shapes.size() != 0 || shape_valid || expected_hits.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic add_polygon(input logic [7:0] body, input logic finish, input logic eoq);
    int n, cx, cy;
    int vx[6], vy[6];
    n = $urandom_range(3, 6);
    cx = rnd_coord(120); cy = rnd_coord(120);
    for (int i = 0; i < n; i++) begin
      vx[i] = cx + rnd_coord(60);
      vy[i] = cy + rnd_coord(60);
    end
    for (int i = 0; i < n; i++)
      push(mk(OP_EDGE, 8'($urandom_range(0, 255)), vx[i], vy[i], vx[(i + 1) % n],
              vy[(i + 1) % n], finish && (i == n - 1), eoq && (i == n - 1)));
    // the last edge carries the body credited
    pending_shapes[pending_shapes.size() - 1].body_id = body;
  endtask

  task automatic add_query();
    int k;
    logic last, noisy;
    logic [159:0] raw;
    shape_t s;
    k = $urandom_range(1, 5);
    noisy = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < k; i++) begin
      last = (i == k - 1);
      if (noisy) begin
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        s = raw[$bits(shape_t)-1:0];
        s.end_of_query = last;
        push(s);
      end else if ($urandom_range(0, 2) == 0) begin
        push(mk(OP_CIRCLE, 8'($urandom_range(0, 255)), rnd_coord(150), rnd_coord(150),
                rnd_coord(80), $urandom, 1'b1, last));
      end else begin
        add_polygon(8'($urandom_range(0, 255)), !(last && $urandom_range(0, 9) == 0), last);
      end
    end
  endtask

  task automatic random_phase(input int items);
    int target;
    target = n_queued + items;
    while (n_queued < target) add_query();
    wait_quiet();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // horizontal segment from x=-10 to x=10
    calm = 1'b0;
    set_segment(-10 * ONE, 0, 10 * ONE, 0);
    push(mk(OP_CIRCLE, 8'd1, 0, 0, 2 * ONE, 0, 1'b1, 1'b1));
    push(mk(OP_CIRCLE, 8'd2, -10 * ONE, ONE, -3 * ONE, 0, 1'b1, 1'b1));   // contains start
    push(mk(OP_EDGE, 8'd3, -5 * ONE, 3 * ONE, 5 * ONE, 3 * ONE, 1'b1, 1'b1)); // parallel
    // square with a circle arriving between its edges, then equal circles
    push(mk(OP_EDGE, 8'd9, -2 * ONE, -2 * ONE, 2 * ONE, -2 * ONE, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd9, 2 * ONE, -2 * ONE, 2 * ONE, 2 * ONE, 1'b0, 1'b0));
    push(mk(OP_CIRCLE, 8'd7, 6 * ONE, 0, ONE, 0, 1'b1, 1'b0));
    push(mk(OP_EDGE, 8'd9, 2 * ONE, 2 * ONE, -2 * ONE, 2 * ONE, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd4, -2 * ONE, 2 * ONE, -2 * ONE, -2 * ONE, 1'b1, 1'b1));
    push(mk(OP_CIRCLE, 8'd5, 0, 0, ONE, 0, 1'b1, 1'b0));
    push(mk(OP_CIRCLE, 8'd6, 0, 0, -ONE, 0, 1'b1, 1'b1));
    // unfinished polygon at query end
    push(mk(OP_EDGE, 8'd8, 0, -ONE, 0, ONE, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd8, 3 * ONE, -ONE, 3 * ONE, ONE, 1'b0, 1'b1));
    // field extremes
    push(mk(OP_CIRCLE, 8'd255, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000,
            1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd0, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
            1'b1, 1'b0));
    push(mk(OP_EDGE, 8'd255, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
            1'b1, 1'b1));
    wait_quiet();

    // zero-length segment: circles never hit, polygons only by parity
    set_segment(ONE, ONE, ONE, ONE);
    push(mk(OP_CIRCLE, 8'd10, ONE, ONE, 5 * ONE, 0, 1'b1, 1'b1));
    push(mk(OP_EDGE, 8'd11, 0, 0, 4 * ONE, 0, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd11, 4 * ONE, 0, 4 * ONE, 4 * ONE, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd11, 4 * ONE, 4 * ONE, 0, 4 * ONE, 1'b0, 1'b0));
    push(mk(OP_EDGE, 8'd12, 0, 4 * ONE, 0, 0, 1'b1, 1'b1));
    wait_quiet();

    set_segment(rnd_coord(100), rnd_coord(100), rnd_coord(100), rnd_coord(100));
    random_phase(300);
    calm = 1'b1;
    set_segment(rnd_coord(150), rnd_coord(150), rnd_coord(150), rnd_coord(150));
    random_phase(200);
    calm = 1'b0;
    set_segment(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    random_phase(100);
    set_segment(32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
    random_phase(80);
    set_segment(rnd_coord(60), rnd_coord(60), rnd_coord(60), rnd_coord(60));
    random_phase(300);

    $display("run covered %0d shape items and %0d result transactions (%0d with a hit)",
             n_items, n_results, n_hits);
    $display("segments: directed, zero-length, random and full-range extremes; mismatches %0d",
             mismatches);
    if (mismatches == 0 && expected_hits.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
